// ===== design/segtri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtri_pkg
// Shared types and constants of the segment against triangle test.
// ----------------------------------------------------------------------------
package segtri_pkg;

   localparam int COORD_BITS      = 24;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int SLOT_COUNT      = 3;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TEST = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   delta_type;

   typedef struct packed {
      logic       action;
      logic [1:0] vertex_slot;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  start_z;
      coord_type  end_x;
      coord_type  end_y;
      coord_type  end_z;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type contact_x;
      coord_type contact_y;
      coord_type contact_z;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_TEST,
      KIND_MISS
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] slot;
      coord_type  ax;
      coord_type  ay;
      coord_type  az;
      delta_type  dx;
      delta_type  dy;
      delta_type  dz;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== design/segtri_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtri_front
// Takes requests, drops bad loads, forms the segment direction and flags
// zero-length segments before they enter the queue.
// ----------------------------------------------------------------------------
module segtri_front import segtri_pkg::*; (
   input  logic         start,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         busy,
   output logic         push,
   output entry_type    push_entry
);

   delta_type dx;
   delta_type dy;
   delta_type dz;
   logic      keep;

   assign dx = delta_type'(req_data.end_x) - delta_type'(req_data.start_x);
   assign dy = delta_type'(req_data.end_y) - delta_type'(req_data.start_y);
   assign dz = delta_type'(req_data.end_z) - delta_type'(req_data.start_z);

   assign keep = (req_data.action == ACTION_TEST) ||
                 (req_data.vertex_slot < 2'(SLOT_COUNT));

   assign busy = q_status.full;
   assign push = start && !q_status.full && keep;

   always_comb begin
      push_entry.slot = req_data.vertex_slot;
      push_entry.ax   = req_data.start_x;
      push_entry.ay   = req_data.start_y;
      push_entry.az   = req_data.start_z;
      push_entry.dx   = dx;
      push_entry.dy   = dy;
      push_entry.dz   = dz;
      if (req_data.action == ACTION_LOAD) begin
         push_entry.kind = KIND_LOAD;
      end else if (dx == '0 && dy == '0 && dz == '0) begin
         push_entry.kind = KIND_MISS;
      end else begin
         push_entry.kind = KIND_TEST;
      end
   end

endmodule

// ===== design/segtri_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtri_queue
// Short first-in first-out queue between request front and test engine.
// ----------------------------------------------------------------------------
module segtri_queue import segtri_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    pop_entry,
   output q_status_type q_status
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff;
   logic [PW-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [PW-1:0]      wr_ptr_in;
   logic [PW-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]   count_in;
   logic               do_pop;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_pop         = pop && !q_status.empty;
   assign pop_entry      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_status.full || do_pop))
      else $error("queue written while full");

endmodule

// ===== design/segtri_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtri_back
// Test engine: holds the triangle, runs a micro-sequenced serial multiplier
// and a restoring divider, and issues one result per test.
// ----------------------------------------------------------------------------
module segtri_back import segtri_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  entry_type    pop_entry,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int CW       = COORD_BITS;
   localparam int WW       = 7 * CW + 16;
   localparam int ND_SHORT = (CW + 1 + 7) / 8;
   localparam int ND_LONG  = (2 * CW + 3 + 7) / 8;
   localparam int YW       = ND_LONG * 8;
   localparam int DGW      = $clog2(ND_LONG);
   localparam int QB       = CW + 1;
   localparam int QCW      = $clog2(QB);

   localparam logic [5:0] PC_PLANE     = 6'd0;
   localparam logic [5:0] PC_PLANE_END = 6'd11;
   localparam logic [5:0] PC_EDGE      = 6'd12;
   localparam logic [5:0] PC_EDGE_END  = 6'd32;
   localparam logic [5:0] PC_CONTACT   = 6'd33;
   localparam logic [5:0] PC_LAST      = 6'd35;

   typedef logic signed [WW-1:0] wide_type;
   typedef logic signed [CW+1:0] cext_type;

   localparam cext_type C_LO = {3'b111, {(CW - 1){1'b0}}};
   localparam cext_type C_HI = {3'b000, {(CW - 1){1'b1}}};

   typedef enum logic [4:0] {
      SRC_SIDE_X, SRC_SIDE_Y, SRC_SIDE_Z,
      SRC_RV_X,   SRC_RV_Y,   SRC_RV_Z,
      SRC_OFF_X,  SRC_OFF_Y,  SRC_OFF_Z,
      SRC_D_X,    SRC_D_Y,    SRC_D_Z,
      SRC_N_X,    SRC_N_Y,    SRC_N_Z,
      SRC_DEN,    SRC_NUM,
      SRC_CP1_X,  SRC_CP1_Y,  SRC_CP1_Z,
      SRC_REL_X,  SRC_REL_Y,  SRC_REL_Z,
      SRC_CP2_X,  SRC_CP2_Y,  SRC_CP2_Z
   } src_type;

   typedef enum logic [4:0] {
      DST_NONE,
      DST_N_X,   DST_N_Y,   DST_N_Z,
      DST_DEN,   DST_NUM,
      DST_CP1_X, DST_CP1_Y, DST_CP1_Z,
      DST_REL_X, DST_REL_Y, DST_REL_Z,
      DST_CP2_X, DST_CP2_Y, DST_CP2_Z,
      DST_DOT,   DST_PROD
   } dst_type;

   typedef struct packed {
      src_type x_sel;
      src_type y_sel;
      logic    long_y;
      logic    sub;
      logic    clr;
      dst_type dst;
   } micro_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_Y,
      ST_MUL,
      ST_ACC,
      ST_PLANE_CHK,
      ST_RANGE_CHK,
      ST_EDGE_CHK,
      ST_DIV_SETUP,
      ST_DIV,
      ST_FIX,
      ST_EMIT
   } state_type;

   function automatic micro_type mk(input src_type xs, input src_type ys, input logic lg,
                                    input logic sb, input logic cl, input dst_type ds);
      micro_type m;
      m.x_sel  = xs;
      m.y_sel  = ys;
      m.long_y = lg;
      m.sub    = sb;
      m.clr    = cl;
      m.dst    = ds;
      return m;
   endfunction

   function automatic micro_type micro(input logic [5:0] pc);
      micro_type m;
      case (pc)
         // plane normal side x rv, then denominator n.d and numerator n.(v0 - a)
         6'd0:  m = mk(SRC_SIDE_Y, SRC_RV_Z, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd1:  m = mk(SRC_SIDE_Z, SRC_RV_Y, 1'b0, 1'b1, 1'b0, DST_N_X);
         6'd2:  m = mk(SRC_SIDE_Z, SRC_RV_X, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd3:  m = mk(SRC_SIDE_X, SRC_RV_Z, 1'b0, 1'b1, 1'b0, DST_N_Y);
         6'd4:  m = mk(SRC_SIDE_X, SRC_RV_Y, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd5:  m = mk(SRC_SIDE_Y, SRC_RV_X, 1'b0, 1'b1, 1'b0, DST_N_Z);
         6'd6:  m = mk(SRC_N_X, SRC_D_X, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd7:  m = mk(SRC_N_Y, SRC_D_Y, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd8:  m = mk(SRC_N_Z, SRC_D_Z, 1'b0, 1'b0, 1'b0, DST_DEN);
         6'd9:  m = mk(SRC_N_X, SRC_OFF_X, 1'b0, 1'b1, 1'b1, DST_NONE);
         6'd10: m = mk(SRC_N_Y, SRC_OFF_Y, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd11: m = mk(SRC_N_Z, SRC_OFF_Z, 1'b0, 1'b1, 1'b0, DST_NUM);
         // edge test
         6'd12: m = mk(SRC_SIDE_Y, SRC_RV_Z, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd13: m = mk(SRC_SIDE_Z, SRC_RV_Y, 1'b0, 1'b1, 1'b0, DST_CP1_X);
         6'd14: m = mk(SRC_SIDE_Z, SRC_RV_X, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd15: m = mk(SRC_SIDE_X, SRC_RV_Z, 1'b0, 1'b1, 1'b0, DST_CP1_Y);
         6'd16: m = mk(SRC_SIDE_X, SRC_RV_Y, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd17: m = mk(SRC_SIDE_Y, SRC_RV_X, 1'b0, 1'b1, 1'b0, DST_CP1_Z);
         6'd18: m = mk(SRC_DEN, SRC_OFF_X, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd19: m = mk(SRC_NUM, SRC_D_X, 1'b0, 1'b0, 1'b0, DST_REL_X);
         6'd20: m = mk(SRC_DEN, SRC_OFF_Y, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd21: m = mk(SRC_NUM, SRC_D_Y, 1'b0, 1'b0, 1'b0, DST_REL_Y);
         6'd22: m = mk(SRC_DEN, SRC_OFF_Z, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd23: m = mk(SRC_NUM, SRC_D_Z, 1'b0, 1'b0, 1'b0, DST_REL_Z);
         6'd24: m = mk(SRC_REL_Z, SRC_SIDE_Y, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd25: m = mk(SRC_REL_Y, SRC_SIDE_Z, 1'b0, 1'b1, 1'b0, DST_CP2_X);
         6'd26: m = mk(SRC_REL_X, SRC_SIDE_Z, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd27: m = mk(SRC_REL_Z, SRC_SIDE_X, 1'b0, 1'b1, 1'b0, DST_CP2_Y);
         6'd28: m = mk(SRC_REL_Y, SRC_SIDE_X, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd29: m = mk(SRC_REL_X, SRC_SIDE_Y, 1'b0, 1'b1, 1'b0, DST_CP2_Z);
         6'd30: m = mk(SRC_CP2_X, SRC_CP1_X, 1'b1, 1'b0, 1'b1, DST_NONE);
         6'd31: m = mk(SRC_CP2_Y, SRC_CP1_Y, 1'b1, 1'b0, 1'b0, DST_NONE);
         6'd32: m = mk(SRC_CP2_Z, SRC_CP1_Z, 1'b1, 1'b0, 1'b0, DST_DOT);
         // contact offsets
         6'd33: m = mk(SRC_NUM, SRC_D_X, 1'b0, 1'b0, 1'b1, DST_PROD);
         6'd34: m = mk(SRC_NUM, SRC_D_Y, 1'b0, 1'b0, 1'b1, DST_PROD);
         6'd35: m = mk(SRC_NUM, SRC_D_Z, 1'b0, 1'b0, 1'b1, DST_PROD);
         default: m = mk(SRC_SIDE_X, SRC_SIDE_X, 1'b0, 1'b0, 1'b1, DST_NONE);
      endcase
      return m;
   endfunction

   state_type        state_ff;
   coord_type        vtx_ff [3][3];
   coord_type        wv_ff [3][3];
   coord_type        a_ff [3];
   delta_type        d_ff [3];
   logic [5:0]       pc_ff;
   logic [1:0]       edge_ff;
   logic [1:0]       axis_ff;
   wide_type         x_ff;
   logic [YW-1:0]    y_sr_ff;
   logic [DGW-1:0]   dig_ff;
   logic             first_ff;
   wide_type         p_ff;
   wide_type         acc_ff;
   wide_type         n_ff [3];
   wide_type         den_ff;
   wide_type         num_ff;
   wide_type         cp1_ff [3];
   wide_type         rel_ff [3];
   wide_type         cp2_ff [3];
   wide_type         dot_ff;
   wide_type         prod_ff;
   logic [WW-1:0]    rem_ff;
   logic [WW-1:0]    dsh_ff;
   logic [QB-1:0]    q_ff;
   logic [QCW-1:0]   qcnt_ff;
   logic             neg_ff;
   coord_type        contact_ff [3];
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   delta_type        side [3];
   delta_type        rv [3];
   delta_type        off [3];
   micro_type        mc;
   wide_type         y_val;
   logic [7:0]       digit;
   logic signed [8:0] dig9;
   logic signed [WW+8:0] part;
   wide_type         p_in;
   wide_type         acc_in;
   wide_type         mag;
   logic [WW-1:0]    rem_in;
   logic             ge;
   cext_type         c_in;
   coord_type        sat_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side[i] = delta_type'(wv_ff[1][i]) - delta_type'(wv_ff[0][i]);
         rv[i]   = delta_type'(wv_ff[2][i]) - delta_type'(wv_ff[0][i]);
         off[i]  = delta_type'(a_ff[i]) - delta_type'(wv_ff[0][i]);
      end
   end

   function automatic wide_type src_val(input src_type s);
      wide_type v;
      case (s)
         SRC_SIDE_X: v = WW'(side[0]);
         SRC_SIDE_Y: v = WW'(side[1]);
         SRC_SIDE_Z: v = WW'(side[2]);
         SRC_RV_X:   v = WW'(rv[0]);
         SRC_RV_Y:   v = WW'(rv[1]);
         SRC_RV_Z:   v = WW'(rv[2]);
         SRC_OFF_X:  v = WW'(off[0]);
         SRC_OFF_Y:  v = WW'(off[1]);
         SRC_OFF_Z:  v = WW'(off[2]);
         SRC_D_X:    v = WW'(d_ff[0]);
         SRC_D_Y:    v = WW'(d_ff[1]);
         SRC_D_Z:    v = WW'(d_ff[2]);
         SRC_N_X:    v = n_ff[0];
         SRC_N_Y:    v = n_ff[1];
         SRC_N_Z:    v = n_ff[2];
         SRC_DEN:    v = den_ff;
         SRC_NUM:    v = num_ff;
         SRC_CP1_X:  v = cp1_ff[0];
         SRC_CP1_Y:  v = cp1_ff[1];
         SRC_CP1_Z:  v = cp1_ff[2];
         SRC_REL_X:  v = rel_ff[0];
         SRC_REL_Y:  v = rel_ff[1];
         SRC_REL_Z:  v = rel_ff[2];
         SRC_CP2_X:  v = cp2_ff[0];
         SRC_CP2_Y:  v = cp2_ff[1];
         SRC_CP2_Z:  v = cp2_ff[2];
         default:    v = '0;
      endcase
      return v;
   endfunction

   assign mc    = micro(pc_ff);
   assign y_val = src_val(mc.y_sel);

   // horner step over the multiplier digits, top digit signed
   assign digit  = y_sr_ff[YW-1 -: 8];
   assign dig9   = first_ff ? {digit[7], digit} : {1'b0, digit};
   assign part   = x_ff * dig9;
   assign p_in   = (p_ff <<< 8) + part[WW-1:0];
   assign acc_in = (mc.clr ? wide_type'(0) : acc_ff) + (mc.sub ? -p_ff : p_ff);

   assign mag    = prod_ff[WW-1] ? -prod_ff : prod_ff;
   assign rem_in = (WW'(mag) << 1) + WW'(den_ff);
   assign ge     = (rem_ff >= dsh_ff);

   always_comb begin
      if (neg_ff) begin
         c_in = cext_type'(a_ff[axis_ff]) - cext_type'({1'b0, q_ff});
      end else begin
         c_in = cext_type'(a_ff[axis_ff]) + cext_type'({1'b0, q_ff});
      end
      if (c_in < C_LO) begin
         sat_in = C_LO[CW-1:0];
      end else if (c_in > C_HI) begin
         sat_in = C_HI[CW-1:0];
      end else begin
         sat_in = c_in[CW-1:0];
      end
   end

   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               vtx_ff[i][j] <= '0;
            end
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  case (pop_entry.kind)
                     KIND_LOAD: begin
                        vtx_ff[pop_entry.slot][0] <= pop_entry.ax;
                        vtx_ff[pop_entry.slot][1] <= pop_entry.ay;
                        vtx_ff[pop_entry.slot][2] <= pop_entry.az;
                     end
                     KIND_MISS: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff       <= '0;
                     end
                     KIND_TEST: begin
                        a_ff[0]  <= pop_entry.ax;
                        a_ff[1]  <= pop_entry.ay;
                        a_ff[2]  <= pop_entry.az;
                        d_ff[0]  <= pop_entry.dx;
                        d_ff[1]  <= pop_entry.dy;
                        d_ff[2]  <= pop_entry.dz;
                        wv_ff    <= vtx_ff;
                        pc_ff    <= PC_PLANE;
                        edge_ff  <= '0;
                        axis_ff  <= '0;
                        state_ff <= ST_LOAD_Y;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_LOAD_Y: begin
               x_ff <= src_val(mc.x_sel);
               if (mc.long_y) begin
                  y_sr_ff <= y_val[YW-1:0];
                  dig_ff  <= DGW'(ND_LONG - 1);
               end else begin
                  y_sr_ff <= {y_val[ND_SHORT*8-1:0], {(YW - ND_SHORT * 8){1'b0}}};
                  dig_ff  <= DGW'(ND_SHORT - 1);
               end
               first_ff <= 1'b1;
               p_ff     <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               p_ff     <= p_in;
               y_sr_ff  <= y_sr_ff << 8;
               first_ff <= 1'b0;
               dig_ff   <= dig_ff - 1'b1;
               if (dig_ff == '0) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               acc_ff <= acc_in;
               case (mc.dst)
                  DST_N_X:   n_ff[0]   <= acc_in;
                  DST_N_Y:   n_ff[1]   <= acc_in;
                  DST_N_Z:   n_ff[2]   <= acc_in;
                  DST_DEN:   den_ff    <= acc_in;
                  DST_NUM:   num_ff    <= acc_in;
                  DST_CP1_X: cp1_ff[0] <= acc_in;
                  DST_CP1_Y: cp1_ff[1] <= acc_in;
                  DST_CP1_Z: cp1_ff[2] <= acc_in;
                  DST_REL_X: rel_ff[0] <= acc_in;
                  DST_REL_Y: rel_ff[1] <= acc_in;
                  DST_REL_Z: rel_ff[2] <= acc_in;
                  DST_CP2_X: cp2_ff[0] <= acc_in;
                  DST_CP2_Y: cp2_ff[1] <= acc_in;
                  DST_CP2_Z: cp2_ff[2] <= acc_in;
                  DST_DOT:   dot_ff    <= acc_in;
                  DST_PROD:  prod_ff   <= acc_in;
                  default: begin
                  end
               endcase
               if (pc_ff == PC_PLANE_END) begin
                  state_ff <= ST_PLANE_CHK;
               end else if (pc_ff == PC_EDGE_END) begin
                  state_ff <= ST_EDGE_CHK;
               end else if (pc_ff inside {[PC_CONTACT:PC_LAST]}) begin
                  state_ff <= ST_DIV_SETUP;
               end else begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= ST_LOAD_Y;
               end
            end
            ST_PLANE_CHK: begin
               if (den_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '0;
                  state_ff     <= ST_IDLE;
               end else begin
                  if (den_ff[WW-1]) begin
                     den_ff <= -den_ff;
                     num_ff <= -num_ff;
                  end
                  state_ff <= ST_RANGE_CHK;
               end
            end
            ST_RANGE_CHK: begin
               if (num_ff[WW-1] || num_ff == '0 || num_ff > den_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '0;
                  state_ff     <= ST_IDLE;
               end else begin
                  pc_ff    <= PC_EDGE;
                  state_ff <= ST_LOAD_Y;
               end
            end
            ST_EDGE_CHK: begin
               if (dot_ff[WW-1]) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '0;
                  state_ff     <= ST_IDLE;
               end else begin
                  wv_ff[0] <= wv_ff[1];
                  wv_ff[1] <= wv_ff[2];
                  wv_ff[2] <= wv_ff[0];
                  if (edge_ff == 2'd2) begin
                     pc_ff <= PC_CONTACT;
                  end else begin
                     edge_ff <= edge_ff + 1'b1;
                     pc_ff   <= PC_EDGE;
                  end
                  state_ff <= ST_LOAD_Y;
               end
            end
            ST_DIV_SETUP: begin
               neg_ff   <= prod_ff[WW-1];
               rem_ff   <= rem_in;
               dsh_ff   <= WW'(den_ff) << QB;
               q_ff     <= '0;
               qcnt_ff  <= QCW'(QB - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (ge) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               q_ff    <= {q_ff[QB-2:0], ge};
               dsh_ff  <= dsh_ff >> 1;
               qcnt_ff <= qcnt_ff - 1'b1;
               if (qcnt_ff == '0) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               contact_ff[axis_ff] <= sat_in;
               if (axis_ff == 2'd2) begin
                  state_ff <= ST_EMIT;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= ST_LOAD_Y;
               end
            end
            ST_EMIT: begin
               rsp_valid_ff     <= 1'b1;
               rsp_ff.hit       <= 1'b1;
               rsp_ff.contact_x <= contact_ff[0];
               rsp_ff.contact_y <= contact_ff[1];
               rsp_ff.contact_z <= contact_ff[2];
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit) |->
         (rsp_ff.contact_x == '0 && rsp_ff.contact_y == '0 && rsp_ff.contact_z == '0))
      else $error("miss result with non-zero contact");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |->
         (!den_ff[WW-1] && !num_ff[WW-1] && num_ff != '0 && num_ff <= den_ff))
      else $error("hit reported outside the plane parameter range");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < {dsh_ff, 1'b0}))
      else $error("division remainder out of bound");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |=> (rsp_valid_ff && rsp_ff.hit && state_ff == ST_IDLE))
      else $error("hit result not issued");

endmodule

// ===== design/segment_triangle_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// Vertex loads are written when popped; a zero-length segment gives its miss when popped.
// A full hit is paced by the shared 8-bit serial multiplier
// (78 products) and three 25-step restoring divisions; early misses end sooner.
// Requests are taken every cycle until the queue is full; tests run one at a time.
// Results are one-cycle strobes. Synchronous reset empties the queue and zeroes
// the triangle.
// ----------------------------------------------------------------------------
module segment_triangle_intersect import segtri_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         push;
   entry_type    push_entry;
   logic         pop;
   entry_type    pop_entry;

   segtri_front u_front (
      .start      (start),
      .req_data   (req_data),
      .q_status   (q_status),
      .busy       (busy),
      .push       (push),
      .push_entry (push_entry)
   );

   segtri_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   segtri_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks segment_triangle_intersect: vertex loads and segment tests are sent
// by command handshake with random gaps. A wide-integer predictor computes
// every expected hit flag and contact point, and each result strobe is
// compared against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
   import segtri_pkg::*;

   typedef logic signed [199:0] wint;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   coord_type tri_pts [0:8];
   rsp_type   pending_rsp [$];
   int        mismatch_count = 0;
   int        idle_cycles = 0;
   bit        timed_out = 1'b0;

   segment_triangle_intersect u_dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic wint cross_x(wint ay, wint az, wint by, wint bz);
      return ay * bz - az * by;
   endfunction

   function automatic coord_type contact_coord(wint a0, wint da, wint num, wint den);
      wint n, mag, q, c;
      n = da * num;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + den) / (2 * den);
      c = (n < 0) ? a0 - q : a0 + q;
      if (c < -(wint'(1) <<< (COORD_BITS - 1)))
         return {1'b1, {(COORD_BITS-1){1'b0}}};
      if (c > (wint'(1) <<< (COORD_BITS - 1)) - 1)
         return {1'b0, {(COORD_BITS-1){1'b1}}};
      return c[COORD_BITS-1:0];
   endfunction

   // inclusive same-side test of the rational crossing point
   function automatic bit on_inner_side(wint s[3], wint d[3], wint num, wint den,
                                        wint r[3], wint p[3], wint q[3]);
      wint e[3], f[3], g[3], c1[3], c2[3];
      for (int i = 0; i < 3; i++) begin
         e[i] = q[i] - p[i];
         f[i] = r[i] - p[i];
         g[i] = den * (s[i] - p[i]) + d[i] * num;
      end
      for (int i = 0; i < 3; i++) begin
         c1[i] = cross_x(e[(i+1)%3], e[(i+2)%3], f[(i+1)%3], f[(i+2)%3]);
         c2[i] = cross_x(e[(i+1)%3], e[(i+2)%3], g[(i+1)%3], g[(i+2)%3]);
      end
      return (c1[0]*c2[0] + c1[1]*c2[1] + c1[2]*c2[2]) >= 0;
   endfunction

   task automatic predict_request(req_type r);
      wint v0[3], v1[3], v2[3], a[3], d[3], e1[3], e2[3], nrm[3];
      wint den, num;
      rsp_type res;
      res = '0;
      if (r.action == ACTION_LOAD) begin
         if (r.vertex_slot < SLOT_COUNT) begin
            tri_pts[r.vertex_slot*3]   = r.start_x;
            tri_pts[r.vertex_slot*3+1] = r.start_y;
            tri_pts[r.vertex_slot*3+2] = r.start_z;
         end
         return;
      end
      for (int i = 0; i < 3; i++) begin
         v0[i] = tri_pts[i]; v1[i] = tri_pts[3+i]; v2[i] = tri_pts[6+i];
      end
      a[0] = r.start_x; a[1] = r.start_y; a[2] = r.start_z;
      d[0] = wint'(r.end_x) - a[0];
      d[1] = wint'(r.end_y) - a[1];
      d[2] = wint'(r.end_z) - a[2];
      for (int i = 0; i < 3; i++) begin
         e1[i] = v1[i] - v0[i]; e2[i] = v2[i] - v0[i];
      end
      for (int i = 0; i < 3; i++)
         nrm[i] = cross_x(e1[(i+1)%3], e1[(i+2)%3], e2[(i+1)%3], e2[(i+2)%3]);
      den = nrm[0]*d[0] + nrm[1]*d[1] + nrm[2]*d[2];
      num = nrm[0]*(v0[0]-a[0]) + nrm[1]*(v0[1]-a[1]) + nrm[2]*(v0[2]-a[2]);
      if (den < 0) begin
         den = -den; num = -num;
      end
      if (!(d[0] == 0 && d[1] == 0 && d[2] == 0) && den != 0 && num > 0 && num <= den
          && on_inner_side(a, d, num, den, v2, v0, v1)
          && on_inner_side(a, d, num, den, v0, v1, v2)
          && on_inner_side(a, d, num, den, v1, v2, v0)) begin
         res.hit = 1'b1;
         res.contact_x = contact_coord(a[0], d[0], num, den);
         res.contact_y = contact_coord(a[1], d[1], num, den);
         res.contact_z = contact_coord(a[2], d[2], num, den);
      end
      pending_rsp.push_back(res);
   endtask

   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_request(req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_request(r);
      random_gap();
   endtask

   function automatic coord_type rand_coord(int span);
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom);
         1: return {1'b1, {(COORD_BITS-1){1'b0}}};
         2: return {1'b0, {(COORD_BITS-1){1'b1}}};
         default: return coord_type'($urandom_range(0, 2*span) - span);
      endcase
   endfunction

   task automatic send_vertex(logic [1:0] slot, coord_type x, coord_type y, coord_type z);
      req_type r;
      r = '0;
      r.action = ACTION_LOAD; r.vertex_slot = slot;
      r.start_x = x; r.start_y = y; r.start_z = z;
      r.end_x = coord_type'($urandom); r.end_y = coord_type'($urandom);
      r.end_z = coord_type'($urandom);
      send_request(r);
   endtask

   task automatic send_segment(coord_type ax, coord_type ay, coord_type az,
                               coord_type bx, coord_type by, coord_type bz);
      req_type r;
      r.action = ACTION_TEST; r.vertex_slot = 2'($urandom);
      r.start_x = ax; r.start_y = ay; r.start_z = az;
      r.end_x = bx; r.end_y = by; r.end_z = bz;
      send_request(r);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      // all-zero triangle after reset: degenerate, miss
      send_segment(0, 0, -256, 0, 0, 256);
      send_vertex(0, 0, 0, 0);
      send_vertex(1, 24'sd2560, 0, 0);
      send_vertex(2, 0, 24'sd2560, 0);
      send_segment(256, 256, -256, 256, 256, 256);     // interior hit
      send_segment(256, 256, 256, 256, 256, 256);      // zero length
      send_segment(0, 0, 256, 2560, 0, 256);           // parallel
      send_segment(256, 256, 256, 256, 256, 512);      // t outside
      send_segment(256, 256, -256, 256, 256, 0);       // t exactly one
      send_segment(256, 256, 0, 256, 256, 256);        // t zero, miss
      send_segment(1280, 0, -256, 1280, 0, 256);       // on edge
      send_segment(0, 0, -256, 0, 0, 256);             // on vertex
      send_segment(2560, 2560, -256, 2560, 2560, 256); // outside triangle
      send_segment(-256, -256, -256, 512, 512, 256);   // oblique
      send_vertex(3, 24'sd999, 24'sd999, 24'sd999);    // ignored slot
      send_segment(256, 256, 256, 256, 256, -256);
      send_vertex(0, {1'b1, 23'd0}, {1'b1, 23'd0}, 0);
      send_vertex(1, {1'b0, {23{1'b1}}}, {1'b1, 23'd0}, 0);
      send_vertex(2, 0, {1'b0, {23{1'b1}}}, 0);
      send_segment({1'b1, 23'd0}, {1'b1, 23'd0}, {1'b1, 23'd0},
                   {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}});
      send_segment(0, 0, {1'b0, {23{1'b1}}}, 0, 0, {1'b1, 23'd0});
      send_segment(24'sd5, 24'sd5, 24'sd1, 24'sd5, 24'sd5, 24'sd1);
   endtask

   task automatic test_drain_pause();
      wait_drained();
      send_segment(0, 0, 1, 0, 0, -1);
   endtask

   task automatic test_random();
      int span;
      coord_type px, py, pz;
      for (int n = 0; n < 1350; n++) begin
         span = ($urandom_range(0, 9) == 0) ? 8388607 : 4096;
         case ($urandom_range(0, 9))
            0, 1: send_vertex(2'($urandom), rand_coord(span), rand_coord(span),
                              rand_coord(span));
            2: begin
               send_vertex(0, rand_coord(span), rand_coord(span), rand_coord(span));
               send_vertex(1, rand_coord(span), rand_coord(span), rand_coord(span));
               send_vertex(2, rand_coord(span), rand_coord(span), rand_coord(span));
            end
            3: begin
               px = rand_coord(span); py = rand_coord(span); pz = rand_coord(span);
               send_segment(px, py, pz, px, py, pz);
            end
            4, 5: begin
               // segment aimed through a vertex mix of the triangle
               px = coord_type'((tri_pts[0] + tri_pts[3] + tri_pts[6]) / 3);
               py = coord_type'((tri_pts[1] + tri_pts[4] + tri_pts[7]) / 3);
               pz = coord_type'((tri_pts[2] + tri_pts[5] + tri_pts[8]) / 3);
               send_segment(px - coord_type'($urandom_range(0, 300)),
                            py + coord_type'($urandom_range(0, 300)),
                            pz - coord_type'($urandom_range(1, 3000)),
                            px + coord_type'($urandom_range(0, 300)),
                            py - coord_type'($urandom_range(0, 300)),
                            pz + coord_type'($urandom_range(0, 3000)));
            end
            default: send_segment(rand_coord(span), rand_coord(span), rand_coord(span),
                                  rand_coord(span), rand_coord(span), rand_coord(span));
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            if (rsp_data !== pending_rsp[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p got %p", pending_rsp[0], rsp_data);
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000 && !timed_out) begin
         timed_out = 1'b1;
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 9; i++) tri_pts[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random();
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end
endmodule
